// File: rtl/core/dcp_pkg.sv
// Shared constants for the delta correlating prefetcher.
`timescale 1ns / 1ps
package dcp_pkg;
    localparam int ADDR_W            = 32;
    localparam int SHIFT_W           = 4;
    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int HISTORY_DEPTH_DEF = 6;
    localparam int DELTA_BITS_DEF    = 9;
    localparam int CELL_GROUP        = 16;
    localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 4'd6;
endpackage

// File: rtl/core/delta_correlating_prefetcher.sv
// Top level: entry row, delta update, pair scan and prefetch emission.
`timescale 1ns / 1ps
// One access is taken when start is high and busy is low. The entry row is
// searched in parallel; the hit payload is gathered along the row in groups
// of 16 cells. An access passes the states LOOK, GATH, SEL and UPD; a hit
// then scans in SCAN and, if a pair is found, emits its prefetch addresses
// (up to HISTORY_DEPTH-2) in EMIT. Each result is shown for one cycle with
// result_valid and cannot be stalled; last_of_run marks the final one.
module delta_correlating_prefetcher #(
    parameter int TABLE_ENTRIES = dcp_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_DEPTH = dcp_pkg::HISTORY_DEPTH_DEF,
    parameter int DELTA_BITS    = dcp_pkg::DELTA_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dcp_pkg::ADDR_W-1:0]   access_pc,
    input  logic [dcp_pkg::ADDR_W-1:0]   access_address,
    output logic                         result_valid,
    output logic [dcp_pkg::ADDR_W-1:0]   prefetch_address,
    output logic                         last_of_run,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dcp_pkg::SHIFT_W-1:0]  cfg_data
);
    localparam int AW     = dcp_pkg::ADDR_W;
    localparam int IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int XW     = $clog2(HISTORY_DEPTH);
    localparam int HW     = HISTORY_DEPTH * DELTA_BITS;
    localparam int DATA_W = AW + HW + CW;
    localparam int G      = dcp_pkg::CELL_GROUP;
    localparam int NG     = (TABLE_ENTRIES + G - 1) / G;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_GATH = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [dcp_pkg::SHIFT_W-1:0] shift_reg;
    logic [IW-1:0]               iptr_reg;
    logic [AW-1:0]               pc_reg, addr_reg;
    logic                        any_hit_reg;
    logic [DATA_W-1:0]           sel_reg;
    logic [DATA_W-1:0]           grp_reg [NG];
    logic [DELTA_BITS-1:0]       hist_reg [HISTORY_DEPTH];
    logic [CW-1:0]               n_reg;
    logic [AW-1:0]               last_reg;
    logic [AW-1:0]               acc_reg;
    logic [CW-1:0]               k_reg;
    logic                        rv_reg, rl_reg;
    logic [AW-1:0]               ra_reg;

    logic [TABLE_ENTRIES-1:0]    hits;
    logic [DATA_W-1:0]           chain_out [TABLE_ENTRIES];
    logic                        do_write;
    logic [DATA_W-1:0]           wr_data;

    // entry row
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        logic [DATA_W-1:0] cin;
        if (i % G == 0)
        begin : g_head
            assign cin = '0;
        end
        else
        begin : g_link
            assign cin = chain_out[i-1];
        end
        dcp_cell #(.DATA_W(DATA_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .lookup    (state_reg == S_LOOK),
            .key       (pc_reg),
            .wr_en     (do_write && (any_hit_reg ? hits[i] : (iptr_reg == IW'(i)))),
            .wr_tag    (pc_reg),
            .wr_data   (wr_data),
            .chain_in  (cin),
            .chain_out (chain_out[i]),
            .hit       (hits[i])
        );
    end

    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        localparam int TAIL = ((g + 1) * G < TABLE_ENTRIES) ? (g + 1) * G - 1
                                                              : TABLE_ENTRIES - 1;
        always_ff @(posedge clk)
        begin
            if (state_reg == S_GATH)
                grp_reg[g] <= chain_out[TAIL];
        end
    end

    logic [DATA_W-1:0] grp_or;
    always_comb
    begin
        grp_or = '0;
        for (int g = 0; g < NG; g++)
            grp_or = grp_or | grp_reg[g];
    end

    // delta from the gathered entry
    logic [AW-1:0]         sel_last;
    logic [CW-1:0]         sel_n;
    logic                  ge;
    logic [AW-1:0]         diff, q;
    logic                  nonzero;
    logic [DELTA_BITS-1:0] stored;
    logic [DELTA_BITS-1:0] uh [HISTORY_DEPTH];
    logic [CW-1:0]         un;
    logic [AW-1:0]         ulast;

    assign sel_last = sel_reg[DATA_W-1 -: AW];
    assign sel_n    = sel_reg[CW-1:0];
    assign ge       = addr_reg >= sel_last;
    assign diff     = ge ? (addr_reg - sel_last) : (sel_last - addr_reg);
    assign q        = diff >> shift_reg;
    assign nonzero  = |q;
    assign stored   = (ge && ((q >> DELTA_BITS) == '0)) ? q[DELTA_BITS-1:0] : '0;

    always_comb
    begin
        for (int j = 0; j < HISTORY_DEPTH; j++)
            uh[j] = sel_reg[CW + j*DELTA_BITS +: DELTA_BITS];
        un    = sel_n;
        ulast = sel_last;
        if (!any_hit_reg)
        begin
            for (int j = 0; j < HISTORY_DEPTH; j++)
                uh[j] = '0;
            uh[0] = DELTA_BITS'(1);
            un    = CW'(1);
            ulast = addr_reg;
        end
        else if (nonzero)
        begin
            ulast = addr_reg;
            if (sel_n == CW'(HISTORY_DEPTH))
            begin
                for (int j = 0; j < HISTORY_DEPTH - 1; j++)
                    uh[j] = uh[j+1];
                uh[HISTORY_DEPTH-1] = stored;
            end
            else
            begin
                uh[sel_n[XW-1:0]] = stored;
                un = sel_n + CW'(1);
            end
        end
    end

    always_comb
    begin
        wr_data = '0;
        wr_data[DATA_W-1 -: AW] = ulast;
        wr_data[CW-1:0]         = un;
        for (int j = 0; j < HISTORY_DEPTH; j++)
            wr_data[CW + j*DELTA_BITS +: DELTA_BITS] = uh[j];
    end
    assign do_write = (state_reg == S_UPD);

    // pair scan, earliest pair wins
    logic [DELTA_BITS-1:0] newest, second;
    logic                  found;
    logic [CW-1:0]         first_k;
    assign newest = hist_reg[XW'(n_reg - CW'(1))];
    assign second = hist_reg[XW'(n_reg - CW'(2))];
    always_comb
    begin
        found   = 1'b0;
        first_k = '0;
        for (int i = HISTORY_DEPTH - 3; i >= 0; i--)
        begin
            if ((CW'(i + 2) < n_reg) && hist_reg[i] == second && hist_reg[i+1] == newest)
            begin
                found   = 1'b1;
                first_k = CW'(i + 2);
            end
        end
    end

    logic [AW-1:0] step_addr;
    logic          is_last;
    assign step_addr = acc_reg + (AW'(hist_reg[k_reg[XW-1:0]]) << shift_reg);
    assign is_last   = (k_reg + CW'(1)) == n_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_LOOK;
            S_LOOK: state_next = S_GATH;
            S_GATH: state_next = S_SEL;
            S_SEL:  state_next = S_UPD;
            S_UPD:  state_next = any_hit_reg ? S_SCAN : S_IDLE;
            S_SCAN: state_next = found ? S_EMIT : S_IDLE;
            S_EMIT: if (is_last) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            shift_reg <= dcp_pkg::BLOCK_SHIFT_RST;
            iptr_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == S_EMIT);
            if (cfg_valid)
                shift_reg <= cfg_data;
            if (state_reg == S_UPD && !any_hit_reg)
                iptr_reg <= (iptr_reg == IW'(TABLE_ENTRIES - 1)) ? '0 : iptr_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            pc_reg   <= access_pc;
            addr_reg <= access_address;
        end
        if (state_reg == S_SEL)
        begin
            sel_reg     <= grp_or;
            any_hit_reg <= |hits;
        end
        if (state_reg == S_UPD)
        begin
            for (int j = 0; j < HISTORY_DEPTH; j++)
                hist_reg[j] <= uh[j];
            n_reg    <= un;
            last_reg <= ulast;
        end
        if (state_reg == S_SCAN)
        begin
            acc_reg <= last_reg;
            k_reg   <= first_k;
        end
        if (state_reg == S_EMIT)
        begin
            acc_reg <= step_addr;
            k_reg   <= k_reg + CW'(1);
            ra_reg  <= step_addr;
            rl_reg  <= is_last;
        end
    end

    assign busy             = (state_reg != S_IDLE);
    assign cfg_ready        = 1'b1;
    assign result_valid     = rv_reg;
    assign prefetch_address = ra_reg;
    assign last_of_run      = rl_reg;
endmodule

// File: rtl/core/dcp_cell.sv
// One table entry: tag compare, masked hand-on of its payload, write port.
`timescale 1ns / 1ps
module dcp_cell #(
    parameter int DATA_W = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       lookup,
    input  logic [dcp_pkg::ADDR_W-1:0] key,
    input  logic                       wr_en,
    input  logic [dcp_pkg::ADDR_W-1:0] wr_tag,
    input  logic [DATA_W-1:0]          wr_data,
    input  logic [DATA_W-1:0]          chain_in,
    output logic [DATA_W-1:0]          chain_out,
    output logic                       hit
);
    logic                       valid_reg;
    logic                       hit_reg;
    logic [dcp_pkg::ADDR_W-1:0] tag_reg;
    logic [DATA_W-1:0]          data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg <= 1'b1;
            if (lookup)
                hit_reg <= valid_reg && (tag_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_reg  <= wr_tag;
            data_reg <= wr_data;
        end
    end

    // only the hit cell adds its payload to what passes along the row
    assign chain_out = chain_in | ({DATA_W{hit_reg}} & data_reg);
    assign hit       = hit_reg;
endmodule
